@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

    localparam int WORD_W          = 64;
    localparam int WORD_BIT_W      = 6;
    localparam int START_W         = 12;
    localparam int COUNT_W         = 13;
    localparam int NUM_BLOCKS_DEF  = 4096;
    localparam int BLOCK_BYTES_DEF = 64;

    localparam logic KIND_ALLOC       = 1'b0;
    localparam logic KIND_RELEASE     = 1'b1;
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NO_SPACE  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [START_W-1:0] start_block;
        logic [COUNT_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [START_W-1:0] first_block;
    } t_rsp;

    // Power-up contents of one bitmap word: the reserved blocks and any
    // padding past the end of the pool read as used.
    function automatic logic [WORD_W-1:0] reset_word(int idx, int num_blocks, int reserved);
        logic [WORD_W-1:0] w;
        int                g;
        w = '0;
        for (int b = 0; b < WORD_W; b++) begin
            g    = idx * WORD_W + b;
            w[b] = (g < reserved) || (g >= num_blocks);
        end
        return w;
    endfunction

endpackage

@@ rtl/ffba_cell.sv @@
module ffba_cell
    import ffba_pkg::*;
#(
    parameter logic [WORD_W-1:0] RST_WORD = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [WORD_W-1:0] i_word,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= RST_WORD;
        end else if (i_shift) begin
            r_word <= i_word;
        end
    end

    assign o_word = r_word;

endmodule

@@ rtl/ffba_mark.sv @@
module ffba_mark
    import ffba_pkg::*;
#(
    parameter int WIDX_W = 6,
    parameter int CMP_W  = 14
) (
    input  logic [WORD_W-1:0] i_word,
    input  logic [WIDX_W-1:0] i_idx,
    input  logic              i_en,
    input  logic              i_set,
    input  logic [CMP_W-1:0]  i_from,
    input  logic [CMP_W-1:0]  i_last,
    output logic [WORD_W-1:0] o_word
);

    logic [WIDX_W-1:0]     w_from_word;
    logic [WIDX_W-1:0]     w_last_word;
    logic [WORD_BIT_W-1:0] w_from_bit;
    logic [WORD_BIT_W-1:0] w_last_bit;
    logic [WORD_W-1:0]     w_lo_mask;
    logic [WORD_W-1:0]     w_hi_mask;
    logic [WORD_W-1:0]     w_mask;

    assign w_from_word = i_from[WORD_BIT_W +: WIDX_W];
    assign w_last_word = i_last[WORD_BIT_W +: WIDX_W];
    assign w_from_bit  = i_from[WORD_BIT_W-1:0];
    assign w_last_bit  = i_last[WORD_BIT_W-1:0];

    always_comb begin
        if (i_idx == w_from_word) begin
            w_lo_mask = {WORD_W{1'b1}} << w_from_bit;
        end else if (i_idx > w_from_word) begin
            w_lo_mask = {WORD_W{1'b1}};
        end else begin
            w_lo_mask = '0;
        end
        if (i_idx == w_last_word) begin
            w_hi_mask = {WORD_W{1'b1}} >> (WORD_BIT_W'(WORD_W - 1) - w_last_bit);
        end else if (i_idx < w_last_word) begin
            w_hi_mask = {WORD_W{1'b1}};
        end else begin
            w_hi_mask = '0;
        end
        w_mask = w_lo_mask & w_hi_mask & {WORD_W{i_en}};
        o_word = i_set ? (i_word | w_mask) : (i_word & ~w_mask);
    end

endmodule

@@ rtl/ffba_scan.sv @@
module ffba_scan
    import ffba_pkg::*;
#(
    parameter int WIDX_W = 6,
    parameter int CMP_W  = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_vld,
    input  logic [WIDX_W-1:0] i_idx,
    input  logic [WORD_W-1:0] i_word,
    input  logic [CMP_W-1:0]  i_len,
    output logic              o_found,
    output logic [CMP_W-1:0]  o_head
);

    // stage A: position of the nearest used bit at or below each bit
    logic                  w_lv [WORD_BIT_W+1][WORD_W];
    logic [WORD_BIT_W-1:0] w_lp [WORD_BIT_W+1][WORD_W];

    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            w_lv[0][j] = i_word[j];
            w_lp[0][j] = WORD_BIT_W'(j);
        end
        for (int k = 0; k < WORD_BIT_W; k++) begin
            for (int j = 0; j < WORD_W; j++) begin
                w_lv[k+1][j] = w_lv[k][j];
                w_lp[k+1][j] = w_lp[k][j];
                if (j >= (1 << k)) begin
                    if (!w_lv[k][j]) begin
                        w_lv[k+1][j] = w_lv[k][j - (1 << k)];
                        w_lp[k+1][j] = w_lp[k][j - (1 << k)];
                    end
                end
            end
        end
    end

    logic                  r_a_vld;
    logic [WIDX_W-1:0]     r_a_idx;
    logic [WORD_W-1:0]     r_a_lv;
    logic [WORD_BIT_W-1:0] r_a_lp [WORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld && !i_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= i_idx;
        for (int j = 0; j < WORD_W; j++) begin
            r_a_lv[j] <= w_lv[WORD_BIT_W][j];
            r_a_lp[j] <= w_lp[WORD_BIT_W][j];
        end
    end

    // stage B: free run ending at each bit, first bit where it reaches len
    logic                  r_found;
    logic [CMP_W-1:0]      r_run;
    logic [CMP_W-1:0]      r_head;
    logic [CMP_W-1:0]      w_rl;
    logic                  w_hit;
    logic [WORD_BIT_W-1:0] w_hit_bit;
    logic [CMP_W-1:0]      w_run_next;
    logic [CMP_W-1:0]      w_end;
    logic [CMP_W-1:0]      w_head_next;

    always_comb begin
        w_hit     = 1'b0;
        w_hit_bit = '0;
        w_rl      = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            w_rl = r_a_lv[j] ? (CMP_W'(j) - CMP_W'(r_a_lp[j])) : (r_run + CMP_W'(j + 1));
            if (w_rl >= i_len) begin
                w_hit     = 1'b1;
                w_hit_bit = WORD_BIT_W'(j);
            end
        end
        w_run_next = r_a_lv[WORD_W-1]
                   ? (CMP_W'(WORD_W - 1) - CMP_W'(r_a_lp[WORD_W-1]))
                   : (r_run + CMP_W'(WORD_W));
        w_end       = CMP_W'({r_a_idx, w_hit_bit});
        w_head_next = w_end + CMP_W'(1) - i_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_found <= 1'b0;
            r_run   <= '0;
        end else if (r_a_vld && !r_found) begin
            r_run <= w_run_next;
            if (w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_vld && !r_found && w_hit) begin
            r_head <= w_head_next;
        end
    end

    assign o_found = r_found;
    assign o_head  = r_head;

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// Channel   Direction  Handshake                   Payload
// request   in         i_req_valid / o_req_ready   i_req (t_req)
// response  out        o_rsp_valid / i_rsp_ready   o_rsp (t_rsp)
//
// The bitmap lives in a ring of W = ceil(NUM_BLOCKS/64) word cells that
// rotates one word per cycle, while scanning or marking, past the scan
// unit and the mark logic. Release: mark lap. Failed allocate: scan lap,
// drain, decide. Successful allocate: scan lap, drain, decide, mark lap.
// Count of 0 or above NUM_BLOCKS: refused without a scan. One request in
// flight; a new one is taken while the previous response waits. Reset is
// synchronous and reloads the reserved-block pattern in the same cycle.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int GIDX_W    = WIDX_W + WORD_BIT_W;
    localparam int CMP_W     = (GIDX_W + 1 > COUNT_W + 1) ? GIDX_W + 1 : COUNT_W + 1;
    localparam int RESERVED  = NUM_BLOCKS / BLOCK_BYTES;
    localparam logic [CMP_W-1:0]  NUM_BLOCKS_C = CMP_W'(NUM_BLOCKS);
    localparam logic [WIDX_W-1:0] LAST_WORD    = WIDX_W'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_MARK,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [WIDX_W-1:0]   r_widx;
    logic [CMP_W-1:0]    r_len;
    logic [CMP_W-1:0]    r_from;
    logic [CMP_W-1:0]    r_last;
    logic                r_mark_en;
    logic                r_set;
    logic                r_status;
    logic [START_W-1:0]  r_first;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic                w_accept;
    logic                w_shift;
    logic                w_lap_end;
    logic                w_rsp_free;
    logic [CMP_W-1:0]    w_start_ext;
    logic [CMP_W-1:0]    w_cnt_ext;
    logic [CMP_W-1:0]    w_rel_end;
    logic [CMP_W-1:0]    w_rel_end_c;
    logic                w_rel_en;
    logic                w_scan_found;
    logic [CMP_W-1:0]    w_scan_head;
    logic [WORD_W-1:0]   w_cell [NUM_WORDS];
    logic [WORD_W-1:0]   w_mark_out;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_shift     = (r_state == S_SCAN) || (r_state == S_MARK);
    assign w_lap_end   = (r_widx == LAST_WORD);
    assign w_rsp_free  = !r_rsp_valid || i_rsp_ready;

    assign w_start_ext = CMP_W'(i_req.start_block);
    assign w_cnt_ext   = CMP_W'(i_req.count);
    assign w_rel_end   = w_start_ext + w_cnt_ext;
    assign w_rel_end_c = (w_rel_end > NUM_BLOCKS_C) ? NUM_BLOCKS_C : w_rel_end;
    assign w_rel_en    = (w_cnt_ext != '0) && (w_start_ext < NUM_BLOCKS_C);

    // bitmap ring: cell 0 is the head, the marked word re-enters at the tail
    for (genvar i = 0; i < NUM_WORDS; i++) begin : g_cell
        localparam logic [WORD_W-1:0] RST_W = reset_word(i, NUM_BLOCKS, RESERVED);
        if (i == NUM_WORDS - 1) begin : g_tail
            ffba_cell #(.RST_WORD(RST_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_word  (w_mark_out),
                .o_word  (w_cell[i])
            );
        end else begin : g_body
            ffba_cell #(.RST_WORD(RST_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_word  (w_cell[i+1]),
                .o_word  (w_cell[i])
            );
        end
    end

    ffba_mark #(.WIDX_W(WIDX_W), .CMP_W(CMP_W)) u_mark (
        .i_word (w_cell[0]),
        .i_idx  (r_widx),
        .i_en   (r_mark_en && (r_state == S_MARK)),
        .i_set  (r_set),
        .i_from (r_from),
        .i_last (r_last),
        .o_word (w_mark_out)
    );

    ffba_scan #(.WIDX_W(WIDX_W), .CMP_W(CMP_W)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_accept),
        .i_vld   (r_state == S_SCAN),
        .i_idx   (r_widx),
        .i_word  (w_cell[0]),
        .i_len   (r_len),
        .o_found (w_scan_found),
        .o_head  (w_scan_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_widx      <= '0;
            r_mark_en   <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_rsp_free) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (w_shift) begin
                r_widx <= w_lap_end ? '0 : r_widx + WIDX_W'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_len   <= w_cnt_ext;
                        r_first <= '0;
                        if (i_req.kind == KIND_RELEASE) begin
                            r_from    <= w_start_ext;
                            r_last    <= w_rel_end_c - CMP_W'(1);
                            r_mark_en <= w_rel_en;
                            r_set     <= 1'b0;
                            r_status  <= STATUS_OK;
                            r_state   <= S_MARK;
                        end else if (w_cnt_ext == '0 || w_cnt_ext > NUM_BLOCKS_C) begin
                            r_status <= STATUS_NO_SPACE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_lap_end) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_scan_found) begin
                        r_from    <= w_scan_head;
                        r_last    <= w_scan_head + r_len - CMP_W'(1);
                        r_mark_en <= 1'b1;
                        r_set     <= 1'b1;
                        r_status  <= STATUS_OK;
                        r_first   <= w_scan_head[START_W-1:0];
                        r_state   <= S_MARK;
                    end else begin
                        r_status <= STATUS_NO_SPACE;
                        r_first  <= '0;
                        r_state  <= S_DONE;
                    end
                end
                S_MARK: begin
                    if (w_lap_end) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_rsp_free) begin
                        r_rsp.status      <= r_status;
                        r_rsp.first_block <= r_first;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_ring_aligned_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_widx == '0))
        else $error("ring not aligned while idle");

    a_request_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

    a_run_within_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_found |-> ((w_scan_head + r_len) <= NUM_BLOCKS_C))
        else $error("found run runs past the pool");

    a_rsp_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_rsp_free) |=> (r_rsp_valid && (r_state == S_IDLE)))
        else $error("response not posted");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ffba_pkg::*;

    localparam int NBLK           = NUM_BLOCKS_DEF;
    localparam int RESERVED       = NUM_BLOCKS_DEF / BLOCK_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 400;
    localparam int MAX_PRINTS     = 40;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    bit [NBLK-1:0] blk_used;
    t_rsp          pending_rsp_q[$];
    int            live_start[$];
    int            live_len[$];

    int req_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int hold_asked    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    int n_mismatch      = 0;
    int n_rsp_seen      = 0;
    int n_alloc_ok      = 0;
    int n_alloc_refused = 0;
    int n_release       = 0;

    first_fit_block_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic t_req mk_req(logic kind, int start, int cnt);
        t_req r;
        r.kind        = kind;
        r.start_block = START_W'(start);
        r.count       = COUNT_W'(cnt);
        return r;
    endfunction

    // first-fit allocate / clamped release, applied at acceptance
    task automatic predict_block_rsp(input t_req r, output t_rsp e);
        int run;
        int head;
        int hit;
        int stop;
        e.status      = STATUS_OK;
        e.first_block = '0;
        if (r.kind == KIND_RELEASE) begin
            stop = int'(r.start_block) + int'(r.count);
            if (stop > NBLK) begin
                stop = NBLK;
            end
            for (int b = int'(r.start_block); b < stop; b++) begin
                blk_used[b] = 1'b0;
            end
            n_release++;
            return;
        end
        hit  = -1;
        run  = 0;
        head = 0;
        if (r.count != 0 && int'(r.count) <= NBLK) begin
            for (int b = 0; b < NBLK && hit < 0; b++) begin
                if (!blk_used[b]) begin
                    if (run == 0) begin
                        head = b;
                    end
                    run++;
                    if (run == int'(r.count)) begin
                        hit = head;
                    end
                end else begin
                    run = 0;
                end
            end
        end
        if (hit < 0) begin
            e.status = STATUS_NO_SPACE;
            n_alloc_refused++;
        end else begin
            for (int b = hit; b < hit + int'(r.count); b++) begin
                blk_used[b] = 1'b1;
            end
            e.first_block = START_W'(hit);
            live_start.push_back(hit);
            live_len.push_back(int'(r.count));
            n_alloc_ok++;
        end
    endtask

    task automatic send_req(t_req r);
        t_rsp want;
        while ($urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        predict_block_rsp(r, want);
        pending_rsp_q.push_back(want);
    endtask

    task automatic check_rsp(t_rsp got);
        t_rsp want;
        n_rsp_seen++;
        if (pending_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response %0d unexpected: status %0d first %0d",
                n_rsp_seen, got.status, got.first_block));
            return;
        end
        want = pending_rsp_q.pop_front();
        if (got.status !== want.status) begin
            report_mismatch($sformatf("response %0d status %0d, want %0d",
                n_rsp_seen, got.status, want.status));
        end
        if (got.first_block !== want.first_block) begin
            report_mismatch($sformatf("response %0d first_block %0d, want %0d",
                n_rsp_seen, got.first_block, want.first_block));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            check_rsp(o_rsp);
        end
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_block_allocator verification failed");
            $finish;
        end
    end

    // mostly well-formed alloc/free traffic on live runs, some raw noise
    function automatic t_req random_req();
        t_req r;
        int   idx;
        int   pick;
        pick = $urandom_range(0, 99);
        r    = '0;
        if (pick < 10) begin
            r.kind        = 1'($urandom_range(0, 1));
            r.start_block = START_W'($urandom);
            r.count       = COUNT_W'($urandom);
        end else if (pick < 50 && live_start.size() > 0) begin
            idx           = $urandom_range(0, live_start.size() - 1);
            r.kind        = KIND_RELEASE;
            r.start_block = START_W'(live_start[idx]);
            r.count       = COUNT_W'(live_len[idx]);
            if ($urandom_range(0, 4) == 0) begin
                r.count = COUNT_W'($urandom_range(0, live_len[idx]));
            end
            live_start.delete(idx);
            live_len.delete(idx);
        end else begin
            r.kind        = KIND_ALLOC;
            r.start_block = START_W'($urandom);
            case ($urandom_range(0, 9))
                0:       r.count = COUNT_W'($urandom_range(65, 1024));
                1:       r.count = COUNT_W'($urandom_range(1025, NBLK));
                default: r.count = COUNT_W'($urandom_range(1, 64));
            endcase
        end
        return r;
    endfunction

    task automatic test_directed();
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        send_req(mk_req(KIND_ALLOC, 0, 0));
        send_req(mk_req(KIND_ALLOC, 0, NBLK));
        send_req(mk_req(KIND_ALLOC, 0, 8191));
        send_req(mk_req(KIND_ALLOC, 0, NBLK + 1));
        send_req(mk_req(KIND_ALLOC, 0, 1));
        send_req(mk_req(KIND_ALLOC, 0, NBLK - RESERVED - 1));
        send_req(mk_req(KIND_ALLOC, 0, 1));
        send_req(mk_req(KIND_RELEASE, NBLK - 1, 1));
        send_req(mk_req(KIND_ALLOC, 0, 1));
        send_req(mk_req(KIND_RELEASE, NBLK - 1, 8191));
        send_req(mk_req(KIND_RELEASE, 100, 0));
        send_req(mk_req(KIND_RELEASE, 0, RESERVED));
        send_req(mk_req(KIND_ALLOC, 0, RESERVED));
        send_req(mk_req(KIND_RELEASE, 0, NBLK));
        send_req(mk_req(KIND_ALLOC, 0, NBLK));
        send_req(mk_req(KIND_RELEASE, 0, NBLK));
        send_req(mk_req(KIND_ALLOC, NBLK - 1, 10));
        send_req(mk_req(KIND_ALLOC, 0, 5));
        send_req(mk_req(KIND_RELEASE, 2, 3));
        send_req(mk_req(KIND_ALLOC, 0, 4));
        send_req(mk_req(KIND_ALLOC, 0, 3));
        send_req(mk_req(KIND_RELEASE, NBLK - 1, NBLK));
        send_req(mk_req(KIND_RELEASE, 0, NBLK));
        live_start.delete();
        live_len.delete();
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (n) send_req(random_req());
    endtask

    // response side held off while requests keep coming, so input stalls
    task automatic test_backpressure();
        req_idle_pct  = 0;
        rsp_stall_pct = 0;
        hold_asked++;
        repeat (24) send_req(random_req());
    endtask

    initial begin
        for (int b = 0; b < RESERVED; b++) begin
            blk_used[b] = 1'b1;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(250, 0, 0);
        test_backpressure();
        test_random(250, 76, 0);
        test_random(250, 0, 76);
        test_random(150, 23, 23);

        i_req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d allocations granted, %0d refused, %0d releases.",
            n_alloc_ok + n_alloc_refused + n_release, n_alloc_ok, n_alloc_refused, n_release);
        $display("Phases: directed corners, free-running, idle sender, stalling receiver, %s %0d.",
            "mixed, long back-pressure; mismatches", n_mismatch);
        if (n_mismatch == 0) begin
            $display("first_fit_block_allocator verification clean");
        end else begin
            $display("first_fit_block_allocator verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/ffba_mark.sv
rtl/ffba_scan.sv
rtl/first_fit_block_allocator.sv
tb/tb_top.sv
